@@ hw/rtl/iqu_pkg.sv @@
// ----------------------------------------------------------------------------
// iqu_pkg
// Shared types and constants for the sensor FIFO quaternion unpacker.
// ----------------------------------------------------------------------------
package iqu_pkg;

    localparam logic [15:0] STATUS_MASK   = 16'h0201;
    localparam logic [15:0] MIN_COUNT     = 16'd2;
    localparam int          HDR1_QUAT_BIT = 2;
    localparam int          HDR1_SEC_BIT  = 11;
    localparam int          HDR2_ACC_BIT  = 4;

    localparam int Q_FRAC = 30;
    localparam int COMP_W = 32;
    localparam int W_W    = 31;
    localparam int ACC_W  = 8;
    localparam int RAD_W  = 31;
    localparam int SQ_W   = 33;
    localparam int SUM_W  = 35;

    localparam logic [SUM_W-1:0] ONE_Q30 = SUM_W'(1) << Q_FRAC;

    localparam int SQRT_STEPS     = 32;
    localparam int SQRT_PER_STAGE = 2;
    localparam int SQRT_STAGES    = SQRT_STEPS / SQRT_PER_STAGE;
    localparam int SQRT_N_W       = 2 * SQRT_STEPS;
    localparam int SQRT_ROOT_W    = SQRT_STEPS;
    localparam int SQRT_REM_W     = SQRT_STEPS + 2;

    typedef struct packed {
        logic                     quat_valid;
        logic signed [COMP_W-1:0] quat_x;
        logic signed [COMP_W-1:0] quat_y;
        logic signed [COMP_W-1:0] quat_z;
        logic                     accuracy_valid;
        logic [ACC_W-1:0]         compass_accuracy;
    } t_side;

endpackage

@@ hw/rtl/iqu_if.sv @@
// ----------------------------------------------------------------------------
// iqu_if
// Valid/ready channels for FIFO poll items and unpacked quaternion items.
// ----------------------------------------------------------------------------
interface iqu_in_if;
    logic               valid;
    logic               ready;
    logic [15:0]        int_status;
    logic [15:0]        fifo_count;
    logic [15:0]        header_one;
    logic [15:0]        header_two;
    logic signed [31:0] quat_x_in;
    logic signed [31:0] quat_y_in;
    logic signed [31:0] quat_z_in;
    logic [7:0]         accuracy_byte;

    modport source (
        output valid, int_status, fifo_count, header_one, header_two,
               quat_x_in, quat_y_in, quat_z_in, accuracy_byte,
        input  ready
    );
    modport sink (
        input  valid, int_status, fifo_count, header_one, header_two,
               quat_x_in, quat_y_in, quat_z_in, accuracy_byte,
        output ready
    );
endinterface

interface iqu_out_if;
    logic               valid;
    logic               ready;
    logic               quat_valid;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
    logic [30:0]        quat_w;
    logic               accuracy_valid;
    logic [7:0]         compass_accuracy;

    modport source (
        output valid, quat_valid, quat_x, quat_y, quat_z, quat_w,
               accuracy_valid, compass_accuracy,
        input  ready
    );
    modport sink (
        input  valid, quat_valid, quat_x, quat_y, quat_z, quat_w,
               accuracy_valid, compass_accuracy,
        output ready
    );
endinterface

@@ hw/rtl/imu_fifo_quaternion_unpack_top.sv @@
// ----------------------------------------------------------------------------
// imu_fifo_quaternion_unpack_top
// Unpacks one sensor FIFO poll per item and rebuilds the quaternion scalar
// part w = floor(sqrt((2^30 - x^2 - y^2 - z^2) * 2^30)) in Q30.
// ----------------------------------------------------------------------------
// The block takes one item per clock when the output does not stall, and
// gives one result item for each, in order. The path from acceptance to the
// output has one stage for packet decode and magnitudes, one for the three
// 32x32 squares, one for the radicand sum and clamp, and 16 square-root
// stages that settle two root bits each. The last root stage is the output
// register; while it waits, earlier stages keep filling any empty slots.
// ----------------------------------------------------------------------------
module imu_fifo_quaternion_unpack_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    iqu_in_if.sink     i_in,
    iqu_out_if.source  o_out
);

    localparam int CW = iqu_pkg::COMP_W;

    logic                        r_va, r_vb, r_vc;
    logic                        rdy_a, rdy_b, rdy_c;
    logic                        sqrt_ready;
    iqu_pkg::t_side              n_side;
    iqu_pkg::t_side              r_side_a, r_side_b, r_side_c;
    logic                        pkt_ok;
    logic [CW-1:0]               r_abs_x, r_abs_y, r_abs_z;
    logic [2*CW-1:0]             prod_x, prod_y, prod_z;
    logic [iqu_pkg::SQ_W-1:0]    r_sq_x, r_sq_y, r_sq_z;
    logic [iqu_pkg::SUM_W-1:0]   sum_sq;
    logic [iqu_pkg::RAD_W-1:0]   n_rad, r_rad;
    iqu_pkg::t_side              out_side;

    assign rdy_c      = !r_vc || sqrt_ready;
    assign rdy_b      = !r_vb || rdy_c;
    assign rdy_a      = !r_va || rdy_b;
    assign i_in.ready = rdy_a;

    always_comb begin
        pkt_ok = ((i_in.int_status & iqu_pkg::STATUS_MASK) != 16'd0) &&
                 (i_in.fifo_count >= iqu_pkg::MIN_COUNT);
        n_side = '0;
        if (pkt_ok && i_in.header_one[iqu_pkg::HDR1_QUAT_BIT]) begin
            n_side.quat_valid = 1'b1;
            n_side.quat_x     = i_in.quat_x_in;
            n_side.quat_y     = i_in.quat_y_in;
            n_side.quat_z     = i_in.quat_z_in;
        end
        if (pkt_ok && i_in.header_one[iqu_pkg::HDR1_SEC_BIT] &&
            i_in.header_two[iqu_pkg::HDR2_ACC_BIT]) begin
            n_side.accuracy_valid   = 1'b1;
            n_side.compass_accuracy = i_in.accuracy_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            if (rdy_a) begin
                r_va <= i_in.valid;
            end
            if (rdy_b) begin
                r_vb <= r_va;
            end
            if (rdy_c) begin
                r_vc <= r_vb;
            end
        end
    end

    // decode and magnitudes
    always_ff @(posedge i_clk) begin
        if (rdy_a) begin
            r_side_a <= n_side;
            r_abs_x  <= n_side.quat_x[CW-1] ? (~n_side.quat_x + 1'b1) : n_side.quat_x;
            r_abs_y  <= n_side.quat_y[CW-1] ? (~n_side.quat_y + 1'b1) : n_side.quat_y;
            r_abs_z  <= n_side.quat_z[CW-1] ? (~n_side.quat_z + 1'b1) : n_side.quat_z;
        end
    end

    // squares in Q30
    assign prod_x = r_abs_x * r_abs_x;
    assign prod_y = r_abs_y * r_abs_y;
    assign prod_z = r_abs_z * r_abs_z;

    always_ff @(posedge i_clk) begin
        if (rdy_b) begin
            r_side_b <= r_side_a;
            r_sq_x   <= prod_x[iqu_pkg::Q_FRAC +: iqu_pkg::SQ_W];
            r_sq_y   <= prod_y[iqu_pkg::Q_FRAC +: iqu_pkg::SQ_W];
            r_sq_z   <= prod_z[iqu_pkg::Q_FRAC +: iqu_pkg::SQ_W];
        end
    end

    // radicand, clamp at zero
    always_comb begin
        sum_sq = iqu_pkg::SUM_W'(r_sq_x) + iqu_pkg::SUM_W'(r_sq_y) +
                 iqu_pkg::SUM_W'(r_sq_z);
        n_rad  = '0;
        if (r_side_b.quat_valid && (sum_sq < iqu_pkg::ONE_Q30)) begin
            n_rad = iqu_pkg::RAD_W'(iqu_pkg::ONE_Q30 - sum_sq);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_c) begin
            r_side_c <= r_side_b;
            r_rad    <= n_rad;
        end
    end

    iqu_sqrt_pipe u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vc),
        .o_ready (sqrt_ready),
        .i_rad   (r_rad),
        .i_side  (r_side_c),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_w     (o_out.quat_w),
        .o_side  (out_side)
    );

    assign o_out.quat_valid       = out_side.quat_valid;
    assign o_out.quat_x           = out_side.quat_x;
    assign o_out.quat_y           = out_side.quat_y;
    assign o_out.quat_z           = out_side.quat_z;
    assign o_out.accuracy_valid   = out_side.accuracy_valid;
    assign o_out.compass_accuracy = out_side.compass_accuracy;

    a_no_quat_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.quat_valid) |->
        (o_out.quat_x == 0 && o_out.quat_y == 0 && o_out.quat_z == 0 &&
         o_out.quat_w == 0))
        else $error("fields set without quaternion");

    a_no_acc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.accuracy_valid) |-> (o_out.compass_accuracy == 0))
        else $error("accuracy set without flag");

    a_w_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.quat_w <= 31'd1073741824))
        else $error("w above one");

    a_rad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vc && !r_side_c.quat_valid) |-> (r_rad == 0))
        else $error("radicand without quaternion");

endmodule

@@ hw/rtl/iqu_sqrt_pipe.sv @@
// ----------------------------------------------------------------------------
// iqu_sqrt_pipe
// Pipelined floor square root of rad * 2^30, two root bits per stage, with
// side payload carried alongside. The last stage is the output register.
// ----------------------------------------------------------------------------
module iqu_sqrt_pipe (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [iqu_pkg::RAD_W-1:0]  i_rad,
    input  iqu_pkg::t_side             i_side,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [iqu_pkg::W_W-1:0]    o_w,
    output iqu_pkg::t_side             o_side
);

    localparam int S  = iqu_pkg::SQRT_STAGES;
    localparam int NW = iqu_pkg::SQRT_N_W;
    localparam int QW = iqu_pkg::SQRT_ROOT_W;
    localparam int RW = iqu_pkg::SQRT_REM_W;
    localparam int PAD_W = NW - iqu_pkg::RAD_W - iqu_pkg::Q_FRAC;

    typedef struct packed {
        logic [NW-1:0] n;
        logic [RW-1:0] rem;
        logic [QW-1:0] root;
    } t_sq_st;

    function automatic t_sq_st sqrt_steps(input t_sq_st s_in);
        t_sq_st        s;
        logic [RW-1:0] rem_sh;
        logic [RW-1:0] trial;
        s = s_in;
        for (int k = 0; k < iqu_pkg::SQRT_PER_STAGE; k++) begin
            rem_sh = {s.rem[RW-3:0], s.n[NW-1 -: 2]};
            trial  = {s.root, 2'b01};
            if (rem_sh >= trial) begin
                s.rem  = rem_sh - trial;
                s.root = {s.root[QW-2:0], 1'b1};
            end else begin
                s.rem  = rem_sh;
                s.root = {s.root[QW-2:0], 1'b0};
            end
            s.n = {s.n[NW-3:0], 2'b00};
        end
        return s;
    endfunction

    logic           r_v  [S];
    t_sq_st         r_st [S];
    iqu_pkg::t_side r_sd [S];
    logic [S:0]     rdy;
    t_sq_st         n_st0;

    always_comb begin
        rdy[S] = i_ready;
        for (int k = S - 1; k >= 0; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
    end

    always_comb begin
        n_st0.n    = {{PAD_W{1'b0}}, i_rad, {iqu_pkg::Q_FRAC{1'b0}}};
        n_st0.rem  = '0;
        n_st0.root = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < S; k++) begin
                r_v[k] <= 1'b0;
            end
        end else begin
            if (rdy[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < S; k++) begin
                if (rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_st[0] <= sqrt_steps(n_st0);
            r_sd[0] <= i_side;
        end
        for (int k = 1; k < S; k++) begin
            if (rdy[k]) begin
                r_st[k] <= sqrt_steps(r_st[k-1]);
                r_sd[k] <= r_sd[k-1];
            end
        end
    end

    assign o_ready = rdy[0];
    assign o_valid = r_v[S-1];
    assign o_w     = r_st[S-1].root[iqu_pkg::W_W-1:0];
    assign o_side  = r_sd[S-1];

endmodule
